FILE: hdl/hzt_pkg.sv
// Shared types and constants for the Hall-sensor zone tracker.
package hzt_pkg;

  localparam int DELTA_BITS = 13;
  localparam int SUM_BITS   = 32;
  localparam int COUNT_BITS = 16;
  localparam int ZONE_BITS  = 3;
  localparam int OP_BITS    = 2;
  localparam int CFG_INDEX_BITS = 3;

  // Operation codes carried by an input beat.
  localparam logic [OP_BITS-1:0] OP_CLASSIFY   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_ACCUMULATE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_COMPUTE    = 2'd2;

  // Zone codes.
  localparam logic [ZONE_BITS-1:0] ZONE_NONE       = 3'd0;
  localparam logic [ZONE_BITS-1:0] ZONE_LOW_HORIZ  = 3'd1;
  localparam logic [ZONE_BITS-1:0] ZONE_LOW_DIAG   = 3'd2;
  localparam logic [ZONE_BITS-1:0] ZONE_LOW_VERT   = 3'd3;
  localparam logic [ZONE_BITS-1:0] ZONE_HIGH_VERT  = 3'd4;
  localparam logic [ZONE_BITS-1:0] ZONE_HIGH_HORIZ = 3'd5;
  localparam logic [ZONE_BITS-1:0] ZONE_RISE_DIAG  = 3'd6;
  localparam logic [ZONE_BITS-1:0] ZONE_FALL_DIAG  = 3'd7;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_HORIZ = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_DIAG  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_VERT  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_VERT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RISE_DIAG = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FALL_DIAG = 3'd5;

  // A delta below this while the rotor sits in a vertical zone starts the fall quarter.
  localparam logic signed [DELTA_BITS-1:0] DELTA_FALL_LIMIT = -13'sd2;

  localparam logic signed [SUM_BITS-1:0] SUM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic add;
    logic clear;
  } acc_ctl_t;

endpackage

FILE: hdl/hzt_in_if.sv
// Input channel: operation, sample and delta with a valid/ready handshake.
interface hzt_in_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                                   valid;
  logic                                   ready;
  logic [hzt_pkg::OP_BITS-1:0]            operation;
  logic [SAMPLE_BITS-1:0]                 sensor_value;
  logic signed [hzt_pkg::DELTA_BITS-1:0]  sensor_delta;

  modport source (output valid, output operation, output sensor_value, output sensor_delta,
                  input ready);
  modport sink (input valid, input operation, input sensor_value, input sensor_delta,
                output ready);
endinterface

FILE: hdl/hzt_out_if.sv
// Result channel: zone, half-turn flags and handed-out sums and counts.
interface hzt_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [hzt_pkg::ZONE_BITS-1:0]         zone;
  logic                                  second_half;
  logic                                  new_half;
  logic                                  rise_ready;
  logic signed [hzt_pkg::SUM_BITS-1:0]   rise_sum;
  logic [hzt_pkg::COUNT_BITS-1:0]        rise_count;
  logic                                  fall_ready;
  logic signed [hzt_pkg::SUM_BITS-1:0]   fall_sum;
  logic [hzt_pkg::COUNT_BITS-1:0]        fall_count;

  modport source (output valid, output zone, output second_half, output new_half,
                  output rise_ready, output rise_sum, output rise_count,
                  output fall_ready, output fall_sum, output fall_count, input ready);
  modport sink (input valid, input zone, input second_half, input new_half,
                input rise_ready, input rise_sum, input rise_count,
                input fall_ready, input fall_sum, input fall_count, output ready);
endinterface

FILE: hdl/hzt_accum.sv
// Saturating delta sum and saturating count for one quarter of the turn.
module hzt_accum (
  input  logic                                  clk,
  input  logic                                  rst,
  input  hzt_pkg::acc_ctl_t                     ctl,
  input  logic signed [hzt_pkg::DELTA_BITS-1:0] delta,
  output logic signed [hzt_pkg::SUM_BITS-1:0]   sum,
  output logic [hzt_pkg::COUNT_BITS-1:0]        count
);

  logic signed [hzt_pkg::SUM_BITS:0]     wide_sum;
  logic signed [hzt_pkg::SUM_BITS-1:0]   sum_next;
  logic [hzt_pkg::COUNT_BITS-1:0]        count_next;

  assign wide_sum = {sum[hzt_pkg::SUM_BITS-1], sum}
                  + {{(hzt_pkg::SUM_BITS + 1 - hzt_pkg::DELTA_BITS)
                      {delta[hzt_pkg::DELTA_BITS-1]}}, delta};

  always_comb begin
    // The two top bits disagree only when the 32-bit sum has overflowed.
    if (wide_sum[hzt_pkg::SUM_BITS] != wide_sum[hzt_pkg::SUM_BITS-1]) begin
      sum_next = wide_sum[hzt_pkg::SUM_BITS] ? hzt_pkg::SUM_MIN : hzt_pkg::SUM_MAX;
    end else begin
      sum_next = wide_sum[hzt_pkg::SUM_BITS-1:0];
    end
    count_next = (&count) ? count : count + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      sum   <= '0;
      count <= '0;
    end else if (ctl.add) begin
      sum   <= sum_next;
      count <= count_next;
    end
  end

endmodule

FILE: hdl/hall_zone_tracker.sv
// Top level of the Hall-sensor zone tracker: input stage, zone and quarter logic, result stage.
//
//  Channel     Direction  Handshake          Carries
//  sample_in   in         valid/ready        operation, sensor_value, sensor_delta
//  result_out  out        valid/ready        zone, half flags, rise/fall sums and counts
//  cfg         in         cfg_write only     cfg_index, cfg_data (threshold levels)
//
// Every beat passes an input register and a result register, one beat per cycle sustained
// while result_out is ready, set by the single update of the tracking state per beat.
// The input register keeps taking beats while a finished result waits, until both are full.
// A synchronous reset clears all tracking state, sums and counts, and returns the threshold
// levels to zero except the high vertical level, which goes to full scale.
module hall_zone_tracker #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  hzt_in_if.sink                                sample_in,
  hzt_out_if.source                             result_out,
  input  logic                                  cfg_write,
  input  logic [hzt_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [SAMPLE_BITS-1:0]                cfg_data
);

  // Threshold levels.
  logic [SAMPLE_BITS-1:0] low_horiz_level;
  logic [SAMPLE_BITS-1:0] low_diag_level;
  logic [SAMPLE_BITS-1:0] low_vert_level;
  logic [SAMPLE_BITS-1:0] high_vert_level;
  logic [SAMPLE_BITS-1:0] rise_diag_level;
  logic [SAMPLE_BITS-1:0] fall_diag_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_horiz_level <= '0;
      low_diag_level  <= '0;
      low_vert_level  <= '0;
      high_vert_level <= '1;
      rise_diag_level <= '0;
      fall_diag_level <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hzt_pkg::REG_LOW_HORIZ: low_horiz_level <= cfg_data;
        hzt_pkg::REG_LOW_DIAG:  low_diag_level  <= cfg_data;
        hzt_pkg::REG_LOW_VERT:  low_vert_level  <= cfg_data;
        hzt_pkg::REG_HIGH_VERT: high_vert_level <= cfg_data;
        hzt_pkg::REG_RISE_DIAG: rise_diag_level <= cfg_data;
        hzt_pkg::REG_FALL_DIAG: fall_diag_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  logic                                  stage_valid;
  logic [hzt_pkg::OP_BITS-1:0]           stage_op;
  logic [SAMPLE_BITS-1:0]                stage_value;
  logic signed [hzt_pkg::DELTA_BITS-1:0] stage_delta;
  logic                                  advance;

  assign advance         = stage_valid && (!result_out.valid || result_out.ready);
  assign sample_in.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample_in.ready) begin
      stage_valid <= sample_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_in.valid && sample_in.ready) begin
      stage_op    <= sample_in.operation;
      stage_value <= sample_in.sensor_value;
      stage_delta <= sample_in.sensor_delta;
    end
  end

  // Tracking state.
  logic [hzt_pkg::ZONE_BITS-1:0] current_zone;
  logic fall_quarter;
  logic half_flag;
  logic half_started;
  logic rise_collecting;
  logic fall_collecting;
  logic rise_pending;
  logic fall_pending;

  logic [hzt_pkg::ZONE_BITS-1:0] current_zone_next;
  logic fall_quarter_next;
  logic half_flag_next;
  logic half_started_next;
  logic rise_collecting_next;
  logic fall_collecting_next;
  logic rise_pending_next;
  logic fall_pending_next;

  logic is_classify;
  logic is_accumulate;
  logic is_compute;
  logic vertical;
  logic quarter_flip;
  logic zone_changed;
  logic [hzt_pkg::ZONE_BITS-1:0] zone_class;
  logic [hzt_pkg::ZONE_BITS-1:0] zone_report;
  logic new_half_report;

  hzt_pkg::acc_ctl_t rise_ctl;
  hzt_pkg::acc_ctl_t fall_ctl;
  logic signed [hzt_pkg::SUM_BITS-1:0] rise_sum;
  logic signed [hzt_pkg::SUM_BITS-1:0] fall_sum;
  logic [hzt_pkg::COUNT_BITS-1:0]      rise_count;
  logic [hzt_pkg::COUNT_BITS-1:0]      fall_count;

  assign is_classify   = stage_op == hzt_pkg::OP_CLASSIFY;
  assign is_accumulate = stage_op == hzt_pkg::OP_ACCUMULATE;
  assign is_compute    = stage_op == hzt_pkg::OP_COMPUTE;
  assign vertical      = (current_zone == hzt_pkg::ZONE_HIGH_VERT)
                      || (current_zone == hzt_pkg::ZONE_LOW_VERT);

  // A vertical visit either opens the fall quarter on a falling delta or closes it.
  assign quarter_flip = vertical
                     && (fall_quarter || (stage_delta < hzt_pkg::DELTA_FALL_LIMIT));
  assign fall_quarter_next = (is_classify && quarter_flip) ? !fall_quarter : fall_quarter;

  always_comb begin
    priority if (stage_value <= low_horiz_level) begin
      zone_class = hzt_pkg::ZONE_LOW_HORIZ;
    end else if (stage_value <= low_diag_level) begin
      zone_class = hzt_pkg::ZONE_LOW_HORIZ;
    end else if (stage_value <= low_vert_level) begin
      zone_class = hzt_pkg::ZONE_LOW_VERT;
    end else if (stage_value >= high_vert_level) begin
      zone_class = hzt_pkg::ZONE_LOW_VERT;
    end else if (!fall_quarter_next && (stage_value < rise_diag_level)) begin
      zone_class = hzt_pkg::ZONE_RISE_DIAG;
    end else if (fall_quarter_next && (stage_value < fall_diag_level)) begin
      zone_class = hzt_pkg::ZONE_FALL_DIAG;
    end else begin
      zone_class = hzt_pkg::ZONE_HIGH_VERT;
    end
  end

  assign zone_changed = is_classify && (quarter_flip || (zone_class != current_zone));
  assign zone_report  = zone_changed ? zone_class : hzt_pkg::ZONE_NONE;

  always_comb begin
    current_zone_next    = current_zone;
    half_flag_next       = half_flag;
    half_started_next    = half_started;
    rise_collecting_next = rise_collecting;
    fall_collecting_next = fall_collecting;
    rise_pending_next    = rise_pending;
    fall_pending_next    = fall_pending;
    rise_ctl             = '0;
    fall_ctl             = '0;

    if (zone_changed) begin
      current_zone_next = zone_class;
      priority if (zone_class == hzt_pkg::ZONE_FALL_DIAG) begin
        if (!fall_pending) fall_collecting_next = 1'b1;
      end else if (zone_class == hzt_pkg::ZONE_RISE_DIAG) begin
        if (!rise_pending) rise_collecting_next = 1'b1;
      end else if (current_zone == hzt_pkg::ZONE_FALL_DIAG) begin
        if (!fall_pending) fall_collecting_next = 1'b0;
      end else if (current_zone == hzt_pkg::ZONE_RISE_DIAG) begin
        if (!rise_pending) rise_collecting_next = 1'b0;
      end else if (current_zone == hzt_pkg::ZONE_LOW_HORIZ) begin
        half_flag_next    = !half_flag;
        half_started_next = 1'b1;
      end else begin
      end
    end

    if (is_accumulate) begin
      if (fall_quarter) begin
        fall_ctl.add = 1'b1;
        if (!fall_collecting) fall_pending_next = 1'b1;
      end else begin
        rise_ctl.add = 1'b1;
        if (!rise_collecting) rise_pending_next = 1'b1;
      end
    end

    if (is_compute) begin
      half_started_next = 1'b0;
      fall_pending_next = 1'b0;
      rise_pending_next = 1'b0;
      fall_ctl.clear    = fall_pending;
      rise_ctl.clear    = rise_pending;
    end

    if (!advance) begin
      rise_ctl = '0;
      fall_ctl = '0;
    end
  end

  // A compute beat reports the half-start flag as it stood before clearing it.
  assign new_half_report = is_compute ? half_started : half_started_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_zone    <= hzt_pkg::ZONE_NONE;
      fall_quarter    <= 1'b0;
      half_flag       <= 1'b0;
      half_started    <= 1'b0;
      rise_collecting <= 1'b0;
      fall_collecting <= 1'b0;
      rise_pending    <= 1'b0;
      fall_pending    <= 1'b0;
    end else if (advance) begin
      current_zone    <= current_zone_next;
      fall_quarter    <= fall_quarter_next;
      half_flag       <= half_flag_next;
      half_started    <= half_started_next;
      rise_collecting <= rise_collecting_next;
      fall_collecting <= fall_collecting_next;
      rise_pending    <= rise_pending_next;
      fall_pending    <= fall_pending_next;
    end
  end

  hzt_accum u_rise_accum (
    .clk   (clk),
    .rst   (rst),
    .ctl   (rise_ctl),
    .delta (stage_delta),
    .sum   (rise_sum),
    .count (rise_count)
  );

  hzt_accum u_fall_accum (
    .clk   (clk),
    .rst   (rst),
    .ctl   (fall_ctl),
    .delta (stage_delta),
    .sum   (fall_sum),
    .count (fall_count)
  );

  // Result register.
  logic handout_rise;
  logic handout_fall;

  assign handout_rise = is_compute && rise_pending;
  assign handout_fall = is_compute && fall_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (advance) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_out.zone        <= zone_report;
      result_out.second_half <= half_flag_next;
      result_out.new_half    <= new_half_report;
      result_out.rise_ready  <= handout_rise;
      result_out.rise_sum    <= handout_rise ? rise_sum : '0;
      result_out.rise_count  <= handout_rise ? rise_count : '0;
      result_out.fall_ready  <= handout_fall;
      result_out.fall_sum    <= handout_fall ? fall_sum : '0;
      result_out.fall_count  <= handout_fall ? fall_count : '0;
    end
  end

endmodule

FILE: tb/sv/hall_zone_tracker_tb.sv
// Self-checking testbench for the Hall-sensor zone tracker with a predicting scoreboard.
`timescale 1ns / 1ps

typedef struct packed {
  logic [hzt_pkg::ZONE_BITS-1:0]         zone;
  logic                                  second_half;
  logic                                  new_half;
  logic                                  rise_ready;
  logic signed [hzt_pkg::SUM_BITS-1:0]   rise_sum;
  logic [hzt_pkg::COUNT_BITS-1:0]        rise_count;
  logic                                  fall_ready;
  logic signed [hzt_pkg::SUM_BITS-1:0]   fall_sum;
  logic [hzt_pkg::COUNT_BITS-1:0]        fall_count;
} hall_result_t;

class zone_scoreboard;
  logic [11:0]                   level [0:5];
  logic [hzt_pkg::ZONE_BITS-1:0] zone_now;
  bit                            fall_quarter;
  bit                            half_flag;
  bit                            half_started;
  bit                            rise_collecting;
  bit                            fall_collecting;
  bit                            rise_pending;
  bit                            fall_pending;
  int                            rise_total;
  int                            fall_total;
  logic [15:0]                   rise_tally;
  logic [15:0]                   fall_tally;
  hall_result_t                  due_results [$];
  int                            failures;

  function new();
    foreach (level[i]) level[i] = 12'd0;
    level[hzt_pkg::REG_HIGH_VERT] = 12'd4095;
    zone_now = hzt_pkg::ZONE_NONE;
    fall_quarter = 0;
    half_flag = 0;
    half_started = 0;
    rise_collecting = 0;
    fall_collecting = 0;
    rise_pending = 0;
    fall_pending = 0;
    rise_total = 0;
    fall_total = 0;
    rise_tally = '0;
    fall_tally = '0;
    failures = 0;
  endfunction

  function void set_level(logic [hzt_pkg::CFG_INDEX_BITS-1:0] idx, logic [11:0] value);
    level[idx] = value;
  endfunction

  function int add_sat(int total, int d);
    longint s;
    s = longint'(total) + longint'(d);
    if (s > longint'(hzt_pkg::SUM_MAX)) s = longint'(hzt_pkg::SUM_MAX);
    if (s < longint'(hzt_pkg::SUM_MIN)) s = longint'(hzt_pkg::SUM_MIN);
    return int'(s);
  endfunction

  // Works out the result of one accepted beat and queues it.
  function void predict_beat(logic [hzt_pkg::OP_BITS-1:0] op, logic [11:0] v,
                             logic signed [hzt_pkg::DELTA_BITS-1:0] delta);
    hall_result_t                  r;
    int                            d;
    logic [hzt_pkg::ZONE_BITS-1:0] last;
    logic [hzt_pkg::ZONE_BITS-1:0] seen;
    bit                            vertical;
    bit                            moved;
    r = '0;
    d = int'(delta);
    if (op == hzt_pkg::OP_CLASSIFY) begin
      last = zone_now;
      vertical = (last == hzt_pkg::ZONE_HIGH_VERT) || (last == hzt_pkg::ZONE_LOW_VERT);
      moved = 0;
      if (!fall_quarter && d < int'(hzt_pkg::DELTA_FALL_LIMIT) && vertical) begin
        fall_quarter = 1;
        moved = 1;
      end else if (fall_quarter && vertical) begin
        fall_quarter = 0;
        moved = 1;
      end
      if (v <= level[hzt_pkg::REG_LOW_HORIZ] || v <= level[hzt_pkg::REG_LOW_DIAG])
        seen = hzt_pkg::ZONE_LOW_HORIZ;
      else if (v <= level[hzt_pkg::REG_LOW_VERT] || v >= level[hzt_pkg::REG_HIGH_VERT])
        seen = hzt_pkg::ZONE_LOW_VERT;
      else if (!fall_quarter && v < level[hzt_pkg::REG_RISE_DIAG])
        seen = hzt_pkg::ZONE_RISE_DIAG;
      else if (fall_quarter && v < level[hzt_pkg::REG_FALL_DIAG])
        seen = hzt_pkg::ZONE_FALL_DIAG;
      else
        seen = hzt_pkg::ZONE_HIGH_VERT;
      if (moved || last != seen) begin
        zone_now = seen;
        r.zone = seen;
        if (seen == hzt_pkg::ZONE_FALL_DIAG) begin
          if (!fall_pending) fall_collecting = 1;
        end else if (seen == hzt_pkg::ZONE_RISE_DIAG) begin
          if (!rise_pending) rise_collecting = 1;
        end else if (last == hzt_pkg::ZONE_FALL_DIAG) begin
          if (!fall_pending) fall_collecting = 0;
        end else if (last == hzt_pkg::ZONE_RISE_DIAG) begin
          if (!rise_pending) rise_collecting = 0;
        end else if (last == hzt_pkg::ZONE_LOW_HORIZ) begin
          half_flag = !half_flag;
          half_started = 1;
        end
      end
    end else if (op == hzt_pkg::OP_ACCUMULATE) begin
      if (fall_quarter) begin
        fall_total = add_sat(fall_total, d);
        if (fall_tally != 16'hFFFF) fall_tally = fall_tally + 16'd1;
        if (!fall_collecting) fall_pending = 1;
      end else begin
        rise_total = add_sat(rise_total, d);
        if (rise_tally != 16'hFFFF) rise_tally = rise_tally + 16'd1;
        if (!rise_collecting) rise_pending = 1;
      end
    end
    r.new_half = half_started;
    if (op == hzt_pkg::OP_COMPUTE) begin
      half_started = 0;
      if (fall_pending) begin
        r.fall_ready = 1;
        r.fall_sum = fall_total;
        r.fall_count = fall_tally;
        fall_total = 0;
        fall_tally = '0;
        fall_pending = 0;
      end
      if (rise_pending) begin
        r.rise_ready = 1;
        r.rise_sum = rise_total;
        r.rise_count = rise_tally;
        rise_total = 0;
        rise_tally = '0;
        rise_pending = 0;
      end
    end
    r.second_half = half_flag;
    due_results.push_back(r);
  endfunction

  function void check_beat(hall_result_t got);
    hall_result_t want;
    bit           bad;
    if (due_results.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("[%0t] result beat with nothing expected: zone=%0d", $realtime, got.zone);
      return;
    end
    want = due_results.pop_front();
    bad = (got.zone !== want.zone) || (got.second_half !== want.second_half) ||
          (got.new_half !== want.new_half) || (got.rise_ready !== want.rise_ready) ||
          (got.rise_sum !== want.rise_sum) || (got.rise_count !== want.rise_count) ||
          (got.fall_ready !== want.fall_ready) || (got.fall_sum !== want.fall_sum) ||
          (got.fall_count !== want.fall_count);
    if (bad) begin
      failures++;
      if (failures <= 10) begin
        $display("[%0t] expected zone=%0d half=%0b new=%0b rise=%0b/%0d/%0d fall=%0b/%0d/%0d",
                 $realtime, want.zone, want.second_half, want.new_half, want.rise_ready,
                 want.rise_sum, want.rise_count, want.fall_ready, want.fall_sum,
                 want.fall_count);
        $display("[%0t] actual   zone=%0d half=%0b new=%0b rise=%0b/%0d/%0d fall=%0b/%0d/%0d",
                 $realtime, got.zone, got.second_half, got.new_half, got.rise_ready,
                 got.rise_sum, got.rise_count, got.fall_ready, got.fall_sum,
                 got.fall_count);
      end
    end
  endfunction
endclass

module hall_zone_tracker_tb;

  localparam int SAMPLE_BITS = 12;
  localparam logic [hzt_pkg::OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200_000;

  logic clk = 1'b0;
  logic rst;
  logic                               cfg_write;
  logic [hzt_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [SAMPLE_BITS-1:0]             cfg_data;

  hzt_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_in ();
  hzt_out_if result_out ();

  hall_zone_tracker #(.SAMPLE_BITS(SAMPLE_BITS)) DUT (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sample_in),
    .result_out (result_out),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  zone_scoreboard sb = new();
  bit no_idle = 0;
  int cycle_count = 0;
  int rotor_pos = 0;
  int rotor_dir = 1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_beat(logic [hzt_pkg::OP_BITS-1:0] op, logic [11:0] v, int d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      sample_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_in.valid        <= 1'b1;
    sample_in.operation    <= op;
    sample_in.sensor_value <= v;
    sample_in.sensor_delta <= d[hzt_pkg::DELTA_BITS-1:0];
    @(posedge clk);
    while (!sample_in.ready) @(posedge clk);
    sb.predict_beat(op, v, d[hzt_pkg::DELTA_BITS-1:0]);
  endtask

  // Stops the input side and waits for every outstanding result.
  task automatic settle();
    sample_in.valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
  endtask

  task automatic load_levels(logic [11:0] lh, logic [11:0] ld, logic [11:0] lv,
                             logic [11:0] hv, logic [11:0] rd, logic [11:0] fd);
    logic [11:0] value [0:5];
    value[hzt_pkg::REG_LOW_HORIZ] = lh;
    value[hzt_pkg::REG_LOW_DIAG]  = ld;
    value[hzt_pkg::REG_LOW_VERT]  = lv;
    value[hzt_pkg::REG_HIGH_VERT] = hv;
    value[hzt_pkg::REG_RISE_DIAG] = rd;
    value[hzt_pkg::REG_FALL_DIAG] = fd;
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= hzt_pkg::CFG_INDEX_BITS'(i);
      cfg_data  <= value[i];
      @(posedge clk);
      sb.set_level(hzt_pkg::CFG_INDEX_BITS'(i), value[i]);
    end
    cfg_write <= 1'b0;
  endtask

  // Mostly a rotor sweeping the sample up and down with matching deltas, mixed with
  // accumulate and compute beats, plus some noise.
  task automatic rotor_beats(int count);
    int pick;
    int prev;
    int d;
    for (int n = 0; n < count; n++) begin
      if (n % 30 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        prev = rotor_pos;
        rotor_pos = rotor_pos + rotor_dir * int'($urandom_range(1, 300));
        if (rotor_pos > 4095) begin
          rotor_pos = 4095;
          rotor_dir = -1;
        end else if (rotor_pos < 0) begin
          rotor_pos = 0;
          rotor_dir = 1;
        end
        d = rotor_pos - prev;
        if ($urandom_range(0, 9) == 0) d = int'($urandom_range(0, 8190)) - 4095;
        send_beat(hzt_pkg::OP_CLASSIFY, rotor_pos[11:0], d);
      end else if (pick < 80) begin
        if ($urandom_range(0, 3) == 0) d = int'($urandom_range(0, 8190)) - 4095;
        else d = int'($urandom_range(0, 200)) - 100;
        send_beat(hzt_pkg::OP_ACCUMULATE, 12'($urandom_range(0, 4095)), d);
      end else if (pick < 92) begin
        send_beat(hzt_pkg::OP_COMPUTE, 12'($urandom_range(0, 4095)),
                  int'($urandom_range(0, 8190)) - 4095);
      end else if (pick < 97) begin
        send_beat(hzt_pkg::OP_CLASSIFY, 12'($urandom_range(0, 4095)),
                  int'($urandom_range(0, 8190)) - 4095);
      end else begin
        send_beat(OP_UNUSED, 12'($urandom_range(0, 4095)),
                  int'($urandom_range(0, 8190)) - 4095);
      end
    end
  endtask

  // Result side: random stalls, each accepted beat checked against the oldest prediction.
  initial begin
    hall_result_t got;
    int stall;
    result_out.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        result_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_out.ready <= 1'b1;
      @(posedge clk);
      while (!result_out.valid) @(posedge clk);
      got.zone        = result_out.zone;
      got.second_half = result_out.second_half;
      got.new_half    = result_out.new_half;
      got.rise_ready  = result_out.rise_ready;
      got.rise_sum    = result_out.rise_sum;
      got.rise_count  = result_out.rise_count;
      got.fall_ready  = result_out.fall_ready;
      got.fall_sum    = result_out.fall_sum;
      got.fall_count  = result_out.fall_count;
      sb.check_beat(got);
    end
  end

  initial begin
    logic [11:0] a;
    logic [11:0] b;
    logic [11:0] c;
    logic [11:0] hv;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_in.valid = 1'b0;
    sample_in.operation = hzt_pkg::OP_CLASSIFY;
    sample_in.sensor_value = '0;
    sample_in.sensor_delta = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Levels straight out of reset.
    send_beat(hzt_pkg::OP_CLASSIFY, 12'd0, 0);
    send_beat(hzt_pkg::OP_CLASSIFY, 12'd4095, 4095);
    send_beat(hzt_pkg::OP_CLASSIFY, 12'd2000, -3);
    settle();

    load_levels(12'd400, 12'd800, 12'd1200, 12'd3600, 12'd2000, 12'd2800);
    send_beat(hzt_pkg::OP_CLASSIFY, 12'd0, 0);
    send_beat(hzt_pkg::OP_CLASSIFY, 12'd600, 5);
    send_beat(hzt_pkg::OP_CLASSIFY, 12'd1000, 5);
    send_beat(hzt_pkg::OP_CLASSIFY, 12'd1500, 3);
    send_beat(hzt_pkg::OP_ACCUMULATE, 12'd0, 4095);
    send_beat(hzt_pkg::OP_ACCUMULATE, 12'd4095, -4095);
    send_beat(hzt_pkg::OP_CLASSIFY, 12'd2500, 5);
    send_beat(hzt_pkg::OP_ACCUMULATE, 12'd0, 100);
    // A falling delta in a vertical zone opens the fall quarter.
    send_beat(hzt_pkg::OP_CLASSIFY, 12'd2500, -3);
    send_beat(hzt_pkg::OP_ACCUMULATE, 12'd0, -50);
    send_beat(hzt_pkg::OP_COMPUTE, 12'd0, 0);
    send_beat(hzt_pkg::OP_CLASSIFY, 12'd3000, -5);
    send_beat(hzt_pkg::OP_ACCUMULATE, 12'd0, -7);
    send_beat(hzt_pkg::OP_CLASSIFY, 12'd3700, 0);
    send_beat(OP_UNUSED, 12'd4095, -4095);
    send_beat(hzt_pkg::OP_COMPUTE, 12'd4095, 4095);
    send_beat(hzt_pkg::OP_CLASSIFY, 12'd0, -4095);
    send_beat(hzt_pkg::OP_CLASSIFY, 12'd2000, 1);
    send_beat(hzt_pkg::OP_CLASSIFY, 12'd3700, 0);
    // Same zone again, but leaving the fall quarter still reports it.
    send_beat(hzt_pkg::OP_CLASSIFY, 12'd3700, 0);
    send_beat(hzt_pkg::OP_COMPUTE, 12'd0, 0);
    settle();

    for (int p = 0; p < 6; p++) begin
      a = 12'($urandom_range(0, 1500));
      b = a + 12'($urandom_range(0, 400));
      c = b + 12'($urandom_range(0, 600));
      hv = 12'($urandom_range(2800, 4095));
      unique case (p)
        0: load_levels(12'd300, 12'd700, 12'd1100, 12'd3500, 12'd2100, 12'd2900);
        1: load_levels(a, b, c, hv, 12'($urandom_range(c, hv)), 12'($urandom_range(c, hv)));
        2: load_levels(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        3: load_levels(12'd0, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095);
        4: load_levels(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        default: load_levels(a, b, c, hv, 12'($urandom_range(0, 4095)),
                             12'($urandom_range(0, 4095)));
      endcase
      rotor_beats(142);
      settle();
    end

    // Allow any stray beat through the two pipeline stages to show up.
    repeat (10) @(posedge clk);
    if (sb.failures == 0 && sb.due_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
